// ----- rtl/tssc_pkg.sv -----
// Shared types and constants for the ternary search spacing cost block.
package tssc_pkg;

    localparam int POINT_W = 30;
    localparam int COST_W  = 52;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic REG_IDX_SEEK_MAX = 1'b0;

    localparam logic [31:0] DIV3_K  = 32'hAAAA_AAAB;
    localparam int          DIV3_SH = 33;

    typedef enum logic [1:0] {
        OP_P,
        OP_Q,
        OP_D
    } t_opsel;

    typedef struct packed {
        logic   load;
        logic   srch_init;
        logic   div;
        logic   split;
        logic   eval_start;
        t_opsel eval_sel;
        logic   save_cp;
        logic   decide;
        logic   scan_init;
        logic   scan_take;
        logic   scan_next;
        logic   finish;
    } t_cmd;

    typedef struct packed {
        logic eval_busy;
        logic wide;
        logic scan_end;
    } t_stat;

endpackage

// ----- rtl/tssc_ctrl.sv -----
// Sequencing state machine for point loading, ternary narrowing and final scan.
module tssc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_last_point,
    input  tssc_pkg::t_stat i_stat,
    output tssc_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_DIV,
        S_SPLIT,
        S_EVP,
        S_WAITP,
        S_EVQ,
        S_WAITQ,
        S_SCAN0,
        S_SEV,
        S_SWAIT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.eval_sel = tssc_pkg::OP_P;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_point) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.srch_init = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_stat.wide ? S_DIV : S_SCAN0;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state = S_EVP;
            end
            S_EVP: begin
                o_cmd.eval_start = 1'b1;
                o_cmd.eval_sel   = tssc_pkg::OP_P;
                n_state = S_WAITP;
            end
            S_WAITP: begin
                if (!i_stat.eval_busy) begin
                    o_cmd.save_cp = 1'b1;
                    n_state = S_EVQ;
                end
            end
            S_EVQ: begin
                o_cmd.eval_start = 1'b1;
                o_cmd.eval_sel   = tssc_pkg::OP_Q;
                n_state = S_WAITQ;
            end
            S_WAITQ: begin
                if (!i_stat.eval_busy) begin
                    o_cmd.decide = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_SCAN0: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SEV;
            end
            S_SEV: begin
                o_cmd.eval_start = 1'b1;
                o_cmd.eval_sel   = tssc_pkg::OP_D;
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (!i_stat.eval_busy) begin
                    o_cmd.scan_take = 1'b1;
                    if (i_stat.scan_end) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state = S_SEV;
                    end
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/tssc_dp.sv -----
// Datapath with point memory, pipelined cost accumulator and search registers.
module tssc_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tssc_pkg::t_cmd                i_cmd,
    input  logic                          i_seek_max,
    input  logic [tssc_pkg::POINT_W-1:0]  i_point_value,
    output tssc_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [tssc_pkg::COST_W-1:0]   o_best_cost,
    output logic                          o_overflow_flag
);

    localparam int PW = tssc_pkg::POINT_W;
    localparam int CW = tssc_pkg::COST_W;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int MW = PW + AW;

    logic [PW-1:0] r_mem [MAX_POINTS];

    logic [NW-1:0] r_count;
    logic          r_dropped;
    logic [PW-1:0] r_last_val;

    logic [PW-1:0] r_lo;
    logic [PW-1:0] r_hi;
    logic [PW-1:0] r_w;
    logic [PW-1:0] r_third;
    logic [PW-1:0] r_p;
    logic [PW-1:0] r_q;
    logic [PW-1:0] r_d;
    logic [CW-1:0] r_cp;
    logic [CW-1:0] r_best;
    logic          r_first;

    logic          r_ev_run;
    logic [NW-1:0] r_ev_idx;
    logic [PW-1:0] r_ev_d;
    logic          r_s1_v;
    logic [MW-1:0] r_s1_prod;
    logic [PW-1:0] r_rd;
    logic          r_s2_v;
    logic [MW-1:0] r_s2_diff;
    logic [CW-1:0] r_acc;

    logic          r_valid;
    logic [CW-1:0] r_out_cost;
    logic          r_out_ovf;

    logic [PW-1:0] w_span;
    logic [63:0]   w_div_prod;
    logic [PW-1:0] w_three_t;
    logic [PW-1:0] w_rem;
    logic [PW-1:0] w_ev_op;
    logic [MW-1:0] w_rd_ext;
    logic          w_keep_left;
    logic          w_better;

    assign w_span     = r_hi - r_lo;
    assign w_div_prod = {{(32 - PW){1'b0}}, r_w} * tssc_pkg::DIV3_K;
    assign w_three_t  = r_third + {r_third[PW-2:0], 1'b0};
    assign w_rem      = r_w - w_three_t;
    assign w_rd_ext   = {{AW{1'b0}}, r_rd};

    always_comb begin
        unique case (i_cmd.eval_sel)
            tssc_pkg::OP_P: w_ev_op = r_p;
            tssc_pkg::OP_Q: w_ev_op = r_q;
            tssc_pkg::OP_D: w_ev_op = r_d;
            default:        w_ev_op = r_d;
        endcase
    end

    assign w_keep_left = i_seek_max ? (r_cp >= r_acc) : (r_cp <= r_acc);
    assign w_better    = i_seek_max ? (r_acc > r_best) : (r_acc < r_best);

    assign o_stat.eval_busy = r_ev_run | r_s1_v | r_s2_v;
    assign o_stat.wide      = (w_span >= PW'(3));
    assign o_stat.scan_end  = (r_d == r_hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < NW'(MAX_POINTS))) begin
            r_mem[r_count[AW-1:0]] <= i_point_value;
        end
        if (r_ev_run) begin
            r_rd <= r_mem[r_ev_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_ev_run  <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else if (i_cmd.load) begin
                if (r_count < NW'(MAX_POINTS)) begin
                    r_count <= r_count + NW'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.eval_start) begin
                r_ev_run <= (r_count > NW'(1));
            end else if (r_ev_run && (r_ev_idx == r_count - NW'(1))) begin
                r_ev_run <= 1'b0;
            end
            r_s1_v <= r_ev_run;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < NW'(MAX_POINTS))) begin
            r_last_val <= i_point_value;
        end

        r_w <= w_span;
        if (i_cmd.div) begin
            r_third <= w_div_prod[tssc_pkg::DIV3_SH +: PW];
        end
        if (i_cmd.split) begin
            r_p <= r_lo + r_third;
            r_q <= r_lo + {r_third[PW-2:0], 1'b0} + PW'(w_rem == PW'(2));
        end

        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_last_val;
        end else if (i_cmd.decide) begin
            if (w_keep_left) begin
                r_hi <= r_q;
            end else begin
                r_lo <= r_p;
            end
        end

        if (i_cmd.save_cp) begin
            r_cp <= r_acc;
        end

        if (i_cmd.scan_init) begin
            r_d     <= r_lo;
            r_first <= 1'b1;
        end else if (i_cmd.scan_take) begin
            r_first <= 1'b0;
            if (r_first || w_better) begin
                r_best <= r_acc;
            end
            if (i_cmd.scan_next) begin
                r_d <= r_d + PW'(1);
            end
        end

        if (i_cmd.eval_start) begin
            r_ev_d   <= w_ev_op;
            r_ev_idx <= NW'(1);
        end else if (r_ev_run) begin
            r_ev_idx <= r_ev_idx + NW'(1);
        end
        if (r_ev_run) begin
            r_s1_prod <= MW'(r_ev_d * r_ev_idx[AW-1:0]);
        end
        if (r_s1_v) begin
            r_s2_diff <= (r_s1_prod >= w_rd_ext) ? (r_s1_prod - w_rd_ext)
                                                 : (w_rd_ext - r_s1_prod);
        end
        if (i_cmd.eval_start) begin
            r_acc <= '0;
        end else if (r_s2_v) begin
            r_acc <= r_acc + CW'(r_s2_diff);
        end

        if (i_cmd.finish) begin
            r_out_cost <= r_best;
            r_out_ovf  <= r_dropped;
        end
    end

    assign o_valid         = r_valid;
    assign o_best_cost     = r_out_cost;
    assign o_overflow_flag = r_out_ovf;

endmodule

// ----- rtl/ternary_search_spacing_cost.sv -----
// Top level of the ternary search spacing cost block with its register port.

// Points load one word per cycle through start while busy is low; the word
// with last point set ends the list and starts the search, and busy stays
// high until the result has been produced. Each cost evaluation streams the
// point memory through one multiply and accumulate lane, each ternary step
// takes two of them plus the check, divide and split states, about log1.5 of
// the last point steps are needed, and the final scan evaluates up to three
// spacings. The result words appear on o_best_cost and o_overflow_flag,
// marked by o_valid, which is high for a single cycle, and cannot be stalled
// by the receiver. The seek_maximum register sits at byte address 0 and
// should be written only while the block is idle.
module ternary_search_spacing_cost #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tssc_pkg::POINT_W-1:0]      i_point_value,
    input  logic                              i_last_point,
    output logic                              o_valid,
    output logic [tssc_pkg::COST_W-1:0]       o_best_cost,
    output logic                              o_overflow_flag,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tssc_pkg::PADDR_W-1:0]      paddr,
    input  logic [tssc_pkg::DATA_W-1:0]       pwdata,
    output logic [tssc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    logic            r_seek_max;
    logic            w_reg_sel;
    tssc_pkg::t_cmd  w_cmd;
    tssc_pkg::t_stat w_stat;

    assign w_reg_sel = (paddr[tssc_pkg::PADDR_W-1] == tssc_pkg::REG_IDX_SEEK_MAX);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? {{(tssc_pkg::DATA_W - 1){1'b0}}, r_seek_max}
                                 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seek_max <= 1'b0;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_seek_max <= pwdata[0];
        end
    end

    tssc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_point (i_last_point),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (busy)
    );

    tssc_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_seek_max      (r_seek_max),
        .i_point_value   (i_point_value),
        .o_stat          (w_stat),
        .o_valid         (o_valid),
        .o_best_cost     (o_best_cost),
        .o_overflow_flag (o_overflow_flag)
    );

endmodule

// ----- tb/tssc_checker.sv -----
// Checker for the spacing cost search: predicts each search result, compares it and checks register reads.
`timescale 1ns / 100ps

module tssc_checker #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [tssc_pkg::POINT_W-1:0]      i_point_value,
    input  logic                              i_last_point,
    input  logic                              o_valid,
    input  logic [tssc_pkg::COST_W-1:0]       o_best_cost,
    input  logic                              o_overflow_flag,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tssc_pkg::PADDR_W-1:0]      paddr,
    input  logic [tssc_pkg::DATA_W-1:0]       pwdata,
    input  logic [tssc_pkg::DATA_W-1:0]       prdata,
    input  logic                              pready,
    output int                                errors,
    output int                                pending,
    output int                                results_checked
);

    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [tssc_pkg::COST_W-1:0] cost;
        logic                        overflow;
    } t_search_result;

    logic [tssc_pkg::POINT_W-1:0] point_mem [MAX_POINTS];
    int                           stored_points;
    logic                         points_dropped;
    logic                         seek_max;
    t_search_result               awaited_results[$];
    t_search_result               answer;
    logic [63:0]                  full_cost;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    function automatic logic [63:0] spacing_cost(input logic [63:0] spacing);
        logic [63:0] sum;
        logic [63:0] want;
        logic [63:0] have;
        int          k;
        sum = '0;
        for (k = 1; k < stored_points; k++) begin
            want = spacing * 64'(k);
            have = {34'd0, point_mem[k]};
            sum += (want >= have) ? (want - have) : (have - want);
        end
        return sum;
    endfunction

    function automatic logic [63:0] predict_best_cost();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] cost_p;
        logic [63:0] cost_q;
        logic [63:0] best;
        logic [63:0] c;
        logic [63:0] d;
        logic        keep_left;
        lo = '0;
        hi = {34'd0, point_mem[stored_points-1]};
        while (hi - lo >= 64'd3) begin
            p = (64'd2 * lo + hi) / 64'd3;
            q = (lo + 64'd2 * hi) / 64'd3;
            cost_p = spacing_cost(p);
            cost_q = spacing_cost(q);
            keep_left = seek_max ? (cost_p >= cost_q) : (cost_p <= cost_q);
            if (keep_left) begin
                hi = q;
            end else begin
                lo = p;
            end
        end
        best = spacing_cost(lo);
        for (d = lo + 64'd1; d <= hi; d++) begin
            c = spacing_cost(d);
            if (seek_max ? (c > best) : (c < best)) begin
                best = c;
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored_points = 0;
            points_dropped = 1'b0;
            seek_max = 1'b0;
            awaited_results.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == {tssc_pkg::REG_IDX_SEEK_MAX, 2'b00}) begin
                        seek_max = pwdata[0];
                    end
                end else if (prdata !== {{(tssc_pkg::DATA_W-1){1'b0}}, seek_max}) begin
                    report_mismatch($sformatf("register read got %0h expected %0h",
                                              prdata, seek_max));
                end
            end
            if (o_valid) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result word with no search pending, cost %0d",
                                              o_best_cost));
                end else begin
                    answer = awaited_results.pop_front();
                    results_checked++;
                    if (o_best_cost !== answer.cost) begin
                        report_mismatch($sformatf("best_cost got %0d expected %0d",
                                                  o_best_cost, answer.cost));
                    end
                    if (o_overflow_flag !== answer.overflow) begin
                        report_mismatch($sformatf("overflow_flag got %0b expected %0b",
                                                  o_overflow_flag, answer.overflow));
                    end
                end
            end
            if (start && !busy) begin
                if (stored_points < MAX_POINTS) begin
                    point_mem[stored_points] = i_point_value;
                    stored_points++;
                end else begin
                    points_dropped = 1'b1;
                end
                if (i_last_point) begin
                    full_cost = predict_best_cost();
                    answer.cost = full_cost[tssc_pkg::COST_W-1:0];
                    answer.overflow = points_dropped;
                    awaited_results.push_back(answer);
                    stored_points = 0;
                    points_dropped = 1'b0;
                end
            end
        end
        pending = awaited_results.size();
    end

endmodule

// ----- tb/tb_ternary_search_spacing_cost.sv -----
// Testbench top for the spacing cost search: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module tb_ternary_search_spacing_cost;

    localparam int CLK_PERIOD     = 20;
    localparam int MAX_POINTS     = 1024;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 240;

    localparam logic [tssc_pkg::POINT_W-1:0] POINT_MAX = {tssc_pkg::POINT_W{1'b1}};

    typedef enum int {
        STYLE_RAMP,
        STYLE_RANDOM,
        STYLE_TINY,
        STYLE_STEEP,
        STYLE_EDGES
    } t_list_style;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [tssc_pkg::POINT_W-1:0]  i_point_value = '0;
    logic                          i_last_point = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [tssc_pkg::PADDR_W-1:0]  paddr = '0;
    logic [tssc_pkg::DATA_W-1:0]   pwdata = '0;
    logic                          busy;
    logic                          o_valid;
    logic [tssc_pkg::COST_W-1:0]   o_best_cost;
    logic                          o_overflow_flag;
    logic [tssc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    int                            errors;
    int                            pending;
    int                            results_checked;
    int                            idle_pct = 32;
    int                            lists_sent = 0;
    int                            points_sent = 0;
    int                            quiet_cycles = 0;
    int                            phase;
    logic [tssc_pkg::POINT_W-1:0]  list_points[$];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    ternary_search_spacing_cost #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_point_value(i_point_value),
        .i_last_point(i_last_point),
        .o_valid(o_valid),
        .o_best_cost(o_best_cost),
        .o_overflow_flag(o_overflow_flag),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    tssc_checker #(
        .MAX_POINTS(MAX_POINTS)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_point_value(i_point_value),
        .i_last_point(i_last_point),
        .o_valid(o_valid),
        .o_best_cost(o_best_cost),
        .o_overflow_flag(o_overflow_flag),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .errors(errors),
        .pending(pending),
        .results_checked(results_checked)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without progress.", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_point(input logic [tssc_pkg::POINT_W-1:0] value, input logic last);
        logic [31:0] junk;
        while ($urandom_range(99) < idle_pct) begin
            junk = $urandom();
            start = 1'b0;
            i_point_value = junk[tssc_pkg::POINT_W-1:0];
            i_last_point = junk[31];
            @(negedge i_clk);
        end
        start = 1'b1;
        i_point_value = value;
        i_last_point = last;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        points_sent++;
    endtask

    task automatic send_list();
        int k;
        for (k = 0; k < list_points.size(); k++) begin
            send_point(list_points[k], k == list_points.size() - 1);
        end
        lists_sent++;
    endtask

    task automatic apb_access(input logic write_en, input logic [tssc_pkg::DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write_en;
        paddr = {tssc_pkg::REG_IDX_SEEK_MAX, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_search_mode(input logic maximum);
        start = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        apb_access(1'b1, {{(tssc_pkg::DATA_W-1){1'b0}}, maximum});
        apb_access(1'b0, '0);
    endtask

    task automatic build_random_list();
        int          len;
        int          pick;
        int          noise;
        int          k;
        t_list_style style;
        logic [63:0] base;
        logic [63:0] v;
        pick = $urandom_range(99);
        if (pick < 8) begin
            len = 1;
        end else if (pick < 75) begin
            len = $urandom_range(12, 2);
        end else if (pick < 95) begin
            len = $urandom_range(40, 13);
        end else begin
            len = $urandom_range(64, 41);
        end
        style = t_list_style'($urandom_range(4));
        base = 64'((style == STYLE_STEEP) ? $urandom_range(1 << 24) : $urandom_range(1 << 20));
        noise = $urandom_range(300);
        list_points.delete();
        for (k = 0; k < len; k++) begin
            case (style)
                STYLE_RAMP, STYLE_STEEP: begin
                    v = base * 64'(k) + 64'($urandom_range(2 * noise));
                    v = (v > 64'(noise)) ? v - 64'(noise) : '0;
                end
                STYLE_RANDOM: begin
                    v = 64'($urandom());
                end
                STYLE_TINY: begin
                    v = 64'($urandom_range(15));
                end
                default: begin
                    pick = $urandom_range(2);
                    v = (pick == 0) ? '0 : (pick == 1) ? {34'd0, POINT_MAX}
                                                       : 64'($urandom());
                end
            endcase
            list_points.push_back(v[tssc_pkg::POINT_W-1:0]);
        end
    endtask

    task automatic send_long_list(input int len);
        int          k;
        logic [63:0] v;
        list_points.delete();
        for (k = 0; k < len; k++) begin
            v = (k < MAX_POINTS) ? 64'(2 * k) + 64'($urandom_range(40)) : 64'($urandom());
            list_points.push_back(v[tssc_pkg::POINT_W-1:0]);
        end
        send_list();
    endtask

    task automatic run_random_phase(input int item_budget);
        int sent;
        sent = 0;
        while (sent < item_budget) begin
            build_random_list();
            sent += list_points.size();
            send_list();
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        apb_access(1'b0, '0);

        list_points = '{30'd0};
        send_list();
        list_points = '{POINT_MAX};
        send_list();
        list_points = '{30'd12345, 30'd0};
        send_list();
        list_points = '{30'd0, 30'd2};
        send_list();
        list_points = '{30'd0, 30'd3};
        send_list();
        list_points = '{30'd0, POINT_MAX, POINT_MAX};
        send_list();
        list_points = '{30'd9, 30'd10, 30'd20, 30'd31, 30'd39};
        send_list();

        set_search_mode(1'b1);
        list_points = '{30'd0, POINT_MAX, POINT_MAX};
        send_list();
        list_points = '{30'd9, 30'd10, 30'd20, 30'd31, 30'd39};
        send_list();
        list_points = '{30'd1, 30'd0, 30'd0, 30'd7};
        send_list();

        set_search_mode(1'b0);
        idle_pct = 0;
        send_long_list(MAX_POINTS + 6);
        idle_pct = 32;

        for (phase = 0; phase < 4; phase++) begin
            set_search_mode(1'(phase % 2));
            idle_pct = (phase == 2) ? 0 : 32;
            run_random_phase(RANDOM_ITEMS);
        end

        start = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d point lists (%0d points) in both search modes, with full and",
                 lists_sent, points_sent);
        $display("overflowed stores among them; %0d search results were compared.",
                 results_checked);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
